// ===== sv/tekd_pkg.sv =====
// ============================================================================
// tekd_pkg: terminal escape key decoder package
// Shared widths, byte codes, key codes, channel structs and the tilde map.
// ============================================================================
package tekd_pkg;

    localparam int BYTE_W = 8;
    localparam int KEY_W  = 5;
    localparam int LEN_W  = 4;

    // Longest sequence body, counted from the control byte
    localparam logic [LEN_W-1:0] MAX_SEQ_LEN = LEN_W'(9);

    localparam logic [BYTE_W-1:0] BYTE_ESC   = 8'h1B;
    localparam logic [BYTE_W-1:0] BYTE_CSI   = 8'h5B;  // '['
    localparam logic [BYTE_W-1:0] BYTE_SS3   = 8'h4F;  // 'O'
    localparam logic [BYTE_W-1:0] CHAR_A     = 8'h41;
    localparam logic [BYTE_W-1:0] CHAR_B     = 8'h42;
    localparam logic [BYTE_W-1:0] CHAR_C     = 8'h43;
    localparam logic [BYTE_W-1:0] CHAR_D     = 8'h44;
    localparam logic [BYTE_W-1:0] CHAR_P     = 8'h50;
    localparam logic [BYTE_W-1:0] CHAR_Q     = 8'h51;
    localparam logic [BYTE_W-1:0] CHAR_R     = 8'h52;
    localparam logic [BYTE_W-1:0] CHAR_S     = 8'h53;
    localparam logic [BYTE_W-1:0] CHAR_0     = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_9     = 8'h39;
    localparam logic [BYTE_W-1:0] CHAR_SEMI  = 8'h3B;
    localparam logic [BYTE_W-1:0] CHAR_TILDE = 8'h7E;

    typedef enum logic [KEY_W-1:0] {
        KEY_NONE   = 5'd0,
        KEY_UP     = 5'd1,
        KEY_DOWN   = 5'd2,
        KEY_RIGHT  = 5'd3,
        KEY_LEFT   = 5'd4,
        KEY_HOME   = 5'd5,
        KEY_INSERT = 5'd6,
        KEY_DELETE = 5'd7,
        KEY_END    = 5'd8,
        KEY_PGUP   = 5'd9,
        KEY_PGDN   = 5'd10,
        KEY_F1     = 5'd11,
        KEY_F2     = 5'd12,
        KEY_F3     = 5'd13,
        KEY_F4     = 5'd14,
        KEY_F5     = 5'd15,
        KEY_F6     = 5'd16,
        KEY_F7     = 5'd17,
        KEY_F8     = 5'd18,
        KEY_F9     = 5'd19,
        KEY_F10    = 5'd20,
        KEY_F11    = 5'd21,
        KEY_F12    = 5'd22
    } key_code_t;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] rx_byte;
    } tekd_item_t;

    typedef struct packed {
        logic      valid;
        key_code_t key;
    } tekd_result_t;

    // Map the number in front of '~' to a key
    function automatic key_code_t tilde_key(input logic [BYTE_W-1:0] n);
        key_code_t k;
        unique case (n)
            8'd1:    k = KEY_HOME;
            8'd2:    k = KEY_INSERT;
            8'd3:    k = KEY_DELETE;
            8'd4:    k = KEY_END;
            8'd5:    k = KEY_PGUP;
            8'd6:    k = KEY_PGDN;
            8'd15:   k = KEY_F5;
            8'd17:   k = KEY_F6;
            8'd18:   k = KEY_F7;
            8'd19:   k = KEY_F8;
            8'd20:   k = KEY_F9;
            8'd21:   k = KEY_F10;
            8'd23:   k = KEY_F11;
            8'd24:   k = KEY_F12;
            default: k = KEY_NONE;
        endcase
        return k;
    endfunction

endpackage

// ===== sv/tekd_if.sv =====
// ============================================================================
// tekd_if: channel interfaces
// Byte input channel and key code output channel, valid/ready handshake.
// ============================================================================
interface tekd_rx_if;
    logic                          valid;
    logic                          ready;
    logic [tekd_pkg::BYTE_W-1:0]   rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface tekd_key_if;
    logic                          valid;
    logic                          ready;
    logic [tekd_pkg::KEY_W-1:0]    key_code;

    modport source (output valid, output key_code, input ready);
    modport sink   (input valid, input key_code, output ready);
endinterface

// ===== sv/tekd_in_stage.sv =====
// ============================================================================
// tekd_in_stage: input register
// Holds one received byte until the decoder takes it.
// ============================================================================
module tekd_in_stage
(
    input  logic                 clk,
    input  logic                 rst_n,
    tekd_rx_if.sink              rx,
    input  logic                 take,
    output tekd_pkg::tekd_item_t item
);

    logic                        valid_reg;
    logic                        valid_next;
    logic [tekd_pkg::BYTE_W-1:0] byte_reg;
    logic                        load;

    assign rx.ready = !valid_reg || take;
    assign load     = rx.valid && rx.ready;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= rx.rx_byte;
        end
    end

    assign item.valid   = valid_reg;
    assign item.rx_byte = byte_reg;

endmodule

// ===== sv/tekd_core.sv =====
// ============================================================================
// tekd_core: sequence state and key decode
// Tracks the escape sequence state and decodes one byte per cycle while the result register has space.
// ============================================================================
module tekd_core
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  tekd_pkg::tekd_item_t   item,
    input  logic                   space,
    output tekd_pkg::tekd_result_t result
);

    logic                        in_seq_reg;
    logic                        in_seq_next;
    logic [tekd_pkg::LEN_W-1:0]  len_reg;
    logic [tekd_pkg::LEN_W-1:0]  len_next;
    logic [tekd_pkg::BYTE_W-1:0] ctrl_reg;
    logic [tekd_pkg::BYTE_W-1:0] ctrl_next;
    logic [tekd_pkg::BYTE_W-1:0] num_reg;
    logic [tekd_pkg::BYTE_W-1:0] num_next;
    logic [11:0]                 num_wide;
    logic [tekd_pkg::BYTE_W-1:0] b;
    logic                        step;

    assign b    = item.rx_byte;
    assign step = item.valid && space;

    // num * 10 + digit, as two shifted adds
    assign num_wide = {3'b000, num_reg, 1'b0} + {1'b0, num_reg, 3'b000}
                      + {8'h00, b[3:0]};

    always_comb
    begin
        in_seq_next  = in_seq_reg;
        len_next     = len_reg;
        ctrl_next    = ctrl_reg;
        num_next     = num_reg;
        result.valid = 1'b0;
        result.key   = tekd_pkg::KEY_NONE;

        if (step)
        begin
            priority if (!in_seq_reg)
            begin
                if (b == tekd_pkg::BYTE_ESC)
                begin
                    in_seq_next = 1'b1;
                end
            end
            else if (len_reg == '0)
            begin
                len_next  = tekd_pkg::LEN_W'(1);
                ctrl_next = b;
            end
            else if (len_reg >= tekd_pkg::MAX_SEQ_LEN)
            begin
                // overlong: drop the sequence
                in_seq_next = 1'b0;
                len_next    = '0;
                num_next    = '0;
            end
            else if (ctrl_reg == tekd_pkg::BYTE_CSI)
            begin
                len_next = len_reg + tekd_pkg::LEN_W'(1);
                priority if (b >= tekd_pkg::CHAR_A && b <= tekd_pkg::CHAR_D)
                begin
                    in_seq_next  = 1'b0;
                    len_next     = '0;
                    num_next     = '0;
                    result.valid = 1'b1;
                    unique case (b[1:0])
                        2'b01:   result.key = tekd_pkg::KEY_UP;
                        2'b10:   result.key = tekd_pkg::KEY_DOWN;
                        2'b11:   result.key = tekd_pkg::KEY_RIGHT;
                        default: result.key = tekd_pkg::KEY_LEFT;
                    endcase
                end
                else if (b >= tekd_pkg::CHAR_0 && b <= tekd_pkg::CHAR_9)
                begin
                    num_next = (num_wide > 12'd255) ? 8'hFF : num_wide[7:0];
                end
                else if (b == tekd_pkg::CHAR_SEMI)
                begin
                    num_next = '0;
                end
                else if (b == tekd_pkg::CHAR_TILDE)
                begin
                    in_seq_next  = 1'b0;
                    len_next     = '0;
                    num_next     = '0;
                    result.valid = 1'b1;
                    result.key   = tekd_pkg::tilde_key(num_reg);
                end
                else
                begin
                    // other bytes keep the sequence open
                end
            end
            else if (ctrl_reg == tekd_pkg::BYTE_SS3)
            begin
                len_next = len_reg + tekd_pkg::LEN_W'(1);
                if (b >= tekd_pkg::CHAR_P && b <= tekd_pkg::CHAR_S)
                begin
                    in_seq_next  = 1'b0;
                    len_next     = '0;
                    num_next     = '0;
                    result.valid = 1'b1;
                    unique case (b[1:0])
                        2'b00:   result.key = tekd_pkg::KEY_F1;
                        2'b01:   result.key = tekd_pkg::KEY_F2;
                        2'b10:   result.key = tekd_pkg::KEY_F3;
                        default: result.key = tekd_pkg::KEY_F4;
                    endcase
                end
            end
            else
            begin
                // unknown control byte: end quietly
                in_seq_next = 1'b0;
                len_next    = '0;
                num_next    = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_seq_reg <= 1'b0;
            len_reg    <= '0;
            ctrl_reg   <= '0;
            num_reg    <= '0;
        end
        else
        begin
            in_seq_reg <= in_seq_next;
            len_reg    <= len_next;
            ctrl_reg   <= ctrl_next;
            num_reg    <= num_next;
        end
    end

endmodule

// ===== sv/tekd_out_stage.sv =====
// ============================================================================
// tekd_out_stage: result register
// Holds one decoded key code until the sink takes it.
// ============================================================================
module tekd_out_stage
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  tekd_pkg::tekd_result_t result,
    output logic                   space,
    tekd_key_if.source             key
);

    logic                valid_reg;
    logic                valid_next;
    tekd_pkg::key_code_t key_reg;
    logic                load;

    assign space = !valid_reg || key.ready;
    assign load  = space && result.valid;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (key.ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            key_reg <= result.key;
        end
    end

    assign key.valid    = valid_reg;
    assign key.key_code = key_reg;

endmodule

// ===== sv/terminal_escape_key_decoder.sv =====
// ============================================================================
// terminal_escape_key_decoder: terminal key escape sequence decoder
// Turns a stream of terminal bytes into key codes for arrows, editing keys
// and F1-F12.
// ============================================================================
// The block takes one byte per clock cycle on rx and gives at most one key
// code on key for each byte. A byte is held in an input register and is
// decoded against the sequence state once the result register has room;
// a decoded key is then written into the result register and shows on key
// from there. Bytes that finish no key give nothing.
// The rate is one byte per cycle as long as key is taken. While a key code
// waits in the result register, decoding holds for every byte, not only for
// the next key. rx then takes one more byte into the input register and
// stalls until key is taken.
module terminal_escape_key_decoder
(
    input  logic       clk,
    input  logic       rst_n,
    tekd_rx_if.sink    rx,
    tekd_key_if.source key
);

    tekd_pkg::tekd_item_t   item;
    tekd_pkg::tekd_result_t result;
    logic                   space;

    tekd_in_stage u_in_stage
    (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx),
        .take  (space),
        .item  (item)
    );

    tekd_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .space  (space),
        .result (result)
    );

    tekd_out_stage u_out_stage
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .result (result),
        .space  (space),
        .key    (key)
    );

endmodule

// ===== verif/tekd_key_checker.sv =====
// ============================================================================
// tekd_key_checker: key decoder scoreboard
// Watches the byte and key channels, decodes every accepted byte with its
// own copy of the escape sequence state, and compares each accepted key code
// with the oldest predicted one.
// ============================================================================
module tekd_key_checker
(
    input  logic clk,
    input  logic rst_n,
    tekd_rx_if   rx,
    tekd_key_if  key,
    output int   fails,
    output int   pending
);

    logic                            seq_open;
    logic [tekd_pkg::LEN_W-1:0]      seq_len;
    logic [tekd_pkg::BYTE_W-1:0]     ctrl_byte;
    logic [tekd_pkg::BYTE_W-1:0]     num_val;

    tekd_pkg::key_code_t predicted_keys[$];

    task automatic report_mismatch(input string what);
        $display("[%0t] key mismatch: %s", $realtime, what);
        fails++;
    endtask

    function automatic void close_seq();
        seq_open = 1'b0;
        seq_len  = '0;
        num_val  = '0;
    endfunction

    function automatic tekd_pkg::key_code_t key_for_number(
        input logic [tekd_pkg::BYTE_W-1:0] n);
        tekd_pkg::key_code_t k;
        k = tekd_pkg::KEY_NONE;
        if (n >= 8'd1 && n <= 8'd6)
            k = tekd_pkg::key_code_t'(tekd_pkg::KEY_W'(tekd_pkg::KEY_HOME)
                                      + tekd_pkg::KEY_W'(n - 8'd1));
        else if (n == 8'd15)
            k = tekd_pkg::KEY_F5;
        else if (n >= 8'd17 && n <= 8'd21)
            k = tekd_pkg::key_code_t'(tekd_pkg::KEY_W'(tekd_pkg::KEY_F6)
                                      + tekd_pkg::KEY_W'(n - 8'd17));
        else if (n == 8'd23 || n == 8'd24)
            k = tekd_pkg::key_code_t'(tekd_pkg::KEY_W'(tekd_pkg::KEY_F11)
                                      + tekd_pkg::KEY_W'(n - 8'd23));
        return k;
    endfunction

    // Advance the sequence state by one byte; return 1 when a key comes out
    function automatic bit decode_byte(input logic [tekd_pkg::BYTE_W-1:0] b,
                                       output tekd_pkg::key_code_t k);
        int acc;
        k = tekd_pkg::KEY_NONE;
        if (!seq_open)
        begin
            if (b == tekd_pkg::BYTE_ESC)
                seq_open = 1'b1;
            return 1'b0;
        end
        if (seq_len == '0)
        begin
            seq_len   = tekd_pkg::LEN_W'(1);
            ctrl_byte = b;
            return 1'b0;
        end
        // Drop sequences that run too long
        if (seq_len >= tekd_pkg::MAX_SEQ_LEN)
        begin
            close_seq();
            return 1'b0;
        end
        seq_len = seq_len + tekd_pkg::LEN_W'(1);

        if (ctrl_byte == tekd_pkg::BYTE_CSI)
        begin
            if (b >= tekd_pkg::CHAR_A && b <= tekd_pkg::CHAR_D)
            begin
                close_seq();
                k = tekd_pkg::key_code_t'(tekd_pkg::KEY_W'(tekd_pkg::KEY_UP)
                                          + tekd_pkg::KEY_W'(b - tekd_pkg::CHAR_A));
                return 1'b1;
            end
            if (b >= tekd_pkg::CHAR_0 && b <= tekd_pkg::CHAR_9)
            begin
                acc     = int'(num_val) * 10 + int'(b - tekd_pkg::CHAR_0);
                num_val = (acc > 255) ? 8'd255 : tekd_pkg::BYTE_W'(acc);
                return 1'b0;
            end
            if (b == tekd_pkg::CHAR_SEMI)
            begin
                num_val = '0;
                return 1'b0;
            end
            if (b == tekd_pkg::CHAR_TILDE)
            begin
                k = key_for_number(num_val);
                close_seq();
                return 1'b1;
            end
            return 1'b0;
        end

        if (ctrl_byte == tekd_pkg::BYTE_SS3)
        begin
            if (b >= tekd_pkg::CHAR_P && b <= tekd_pkg::CHAR_S)
            begin
                close_seq();
                k = tekd_pkg::key_code_t'(tekd_pkg::KEY_W'(tekd_pkg::KEY_F1)
                                          + tekd_pkg::KEY_W'(b - tekd_pkg::CHAR_P));
                return 1'b1;
            end
            return 1'b0;
        end

        close_seq();
        return 1'b0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        tekd_pkg::key_code_t want;
        tekd_pkg::key_code_t got;
        if (!rst_n)
        begin
            seq_open  = 1'b0;
            seq_len   = '0;
            ctrl_byte = '0;
            num_val   = '0;
            predicted_keys.delete();
            fails   = 0;
            pending = 0;
        end
        else
        begin
            if (key.valid && key.ready)
            begin
                if (predicted_keys.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected key %0d", key.key_code));
                end
                else
                begin
                    want = predicted_keys.pop_front();
                    if (key.key_code !== want)
                        report_mismatch($sformatf("key_code got %0d, want %0d (%s)",
                                                  key.key_code, want, want.name()));
                end
            end
            if (rx.valid && rx.ready)
            begin
                if (decode_byte(rx.rx_byte, got))
                    predicted_keys.push_back(got);
            end
            pending = predicted_keys.size();
        end
    end

endmodule

// ===== verif/testbench.sv =====
// ============================================================================
// testbench: terminal escape key decoder test
// Feeds directed and random byte streams of escape sequences with random
// gaps and back-pressure, and lets the checker compare the key codes.
// ============================================================================
module testbench;

    localparam int SEQ_ITEMS     = 1650;
    localparam int IDLE_LIMIT    = 2000;
    localparam int HOLD_CYCLES   = 250;
    localparam int HOLD_AFTER    = 600;
    localparam int DRAIN_CYCLES  = 8;

    logic clk;
    logic rst_n;
    int   fails;
    int   pending;
    int   bytes_sent;
    int   seq_bytes;

    logic [tekd_pkg::BYTE_W-1:0] byte_stream[$];

    tekd_rx_if  rx_ch();
    tekd_key_if key_ch();

    terminal_escape_key_decoder uut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .key   (key_ch)
    );

    tekd_key_checker u_checker
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rx      (rx_ch),
        .key     (key_ch),
        .fails   (fails),
        .pending (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Mostly back to back, sometimes short gaps, rarely long ones
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 62)
            return 0;
        if (r < 86)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic add_byte(input logic [tekd_pkg::BYTE_W-1:0] b);
        byte_stream.push_back(b);
        seq_bytes++;
    endtask

    task automatic open_seq(input logic [tekd_pkg::BYTE_W-1:0] ctrl);
        add_byte(tekd_pkg::BYTE_ESC);
        add_byte(ctrl);
    endtask

    task automatic add_number(input int n);
        if (n >= 100)
            add_byte(tekd_pkg::CHAR_0 + tekd_pkg::BYTE_W'(n / 100));
        if (n >= 10)
            add_byte(tekd_pkg::CHAR_0 + tekd_pkg::BYTE_W'((n / 10) % 10));
        add_byte(tekd_pkg::CHAR_0 + tekd_pkg::BYTE_W'(n % 10));
    endtask

    // Bytes in 0x20-0x2F mean nothing under CSI or SS3
    task automatic add_filler(input int n);
        repeat (n) add_byte(tekd_pkg::BYTE_W'($urandom_range(8'h20, 8'h2F)));
    endtask

    task automatic build_directed();
        logic [tekd_pkg::BYTE_W-1:0] seq[] = '{
            8'h00, 8'hFF,
            tekd_pkg::BYTE_ESC, tekd_pkg::BYTE_CSI, tekd_pkg::CHAR_A,
            tekd_pkg::BYTE_ESC, tekd_pkg::BYTE_SS3, tekd_pkg::CHAR_S,
            tekd_pkg::BYTE_ESC, tekd_pkg::BYTE_CSI, tekd_pkg::CHAR_0 + 8'd2,
            tekd_pkg::CHAR_0 + 8'd4, tekd_pkg::CHAR_TILDE,
            tekd_pkg::BYTE_ESC, tekd_pkg::BYTE_CSI, tekd_pkg::CHAR_9,
            tekd_pkg::CHAR_9, tekd_pkg::CHAR_9, tekd_pkg::CHAR_TILDE,
            tekd_pkg::BYTE_ESC, 8'h78, 8'h61
        };
        foreach (seq[i])
            byte_stream.push_back(seq[i]);
    endtask

    task automatic build_random();
        int known_nums[14] = '{1, 2, 3, 4, 5, 6, 15, 17, 18, 19, 20, 21, 23, 24};
        int kind;
        logic [tekd_pkg::BYTE_W-1:0] ctrl;
        seq_bytes = 0;
        while (seq_bytes < SEQ_ITEMS)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 26)
            begin
                open_seq(tekd_pkg::BYTE_CSI);
                add_filler($urandom_range(0, 2));
                add_byte(tekd_pkg::CHAR_A + tekd_pkg::BYTE_W'($urandom_range(0, 3)));
            end
            else if (kind < 50)
            begin
                open_seq(tekd_pkg::BYTE_CSI);
                if ($urandom_range(0, 3) == 0)
                begin
                    add_number($urandom_range(0, 30));
                    add_byte(tekd_pkg::CHAR_SEMI);
                end
                if ($urandom_range(0, 9) < 7)
                    add_number(known_nums[$urandom_range(0, 13)]);
                else
                    add_number($urandom_range(0, 300));
                add_byte(tekd_pkg::CHAR_TILDE);
            end
            else if (kind < 66)
            begin
                open_seq(tekd_pkg::BYTE_SS3);
                add_filler($urandom_range(0, 2));
                add_byte(tekd_pkg::CHAR_P + tekd_pkg::BYTE_W'($urandom_range(0, 3)));
            end
            else if (kind < 74)
            begin
                // Idle noise, any byte value
                repeat ($urandom_range(1, 4))
                    add_byte(tekd_pkg::BYTE_W'($urandom_range(0, 255)));
            end
            else if (kind < 81)
            begin
                // Around the length limit: seven digits still decode, eight do not
                open_seq(tekd_pkg::BYTE_CSI);
                repeat ($urandom_range(6, 11))
                    add_byte(tekd_pkg::CHAR_0 + tekd_pkg::BYTE_W'($urandom_range(0, 9)));
                add_byte($urandom_range(0, 1) ? tekd_pkg::CHAR_TILDE : tekd_pkg::CHAR_B);
            end
            else if (kind < 87)
            begin
                do
                    ctrl = tekd_pkg::BYTE_W'($urandom_range(0, 255));
                while (ctrl == tekd_pkg::BYTE_CSI || ctrl == tekd_pkg::BYTE_SS3);
                open_seq(ctrl);
                add_byte(tekd_pkg::BYTE_W'($urandom_range(0, 255)));
            end
            else if (kind < 94)
            begin
                open_seq($urandom_range(0, 1) ? tekd_pkg::BYTE_CSI : tekd_pkg::BYTE_SS3);
                repeat ($urandom_range(1, 6))
                    add_byte(tekd_pkg::BYTE_W'($urandom_range(0, 255)));
            end
            else
            begin
                // ESC inside an open sequence is just another byte
                open_seq($urandom_range(0, 1) ? tekd_pkg::BYTE_CSI : tekd_pkg::BYTE_SS3);
                add_byte(tekd_pkg::BYTE_ESC);
                add_byte($urandom_range(0, 1) ? tekd_pkg::CHAR_D : tekd_pkg::CHAR_Q);
            end
        end
    endtask

    initial
    begin
        rx_ch.valid    = 1'b0;
        rx_ch.rx_byte  = '0;
        key_ch.ready   = 1'b0;
        bytes_sent     = 0;
        rst_n          = 1'b0;
        build_directed();
        build_random();
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
    end

    // Byte sender
    initial
    begin
        int gap;
        logic [tekd_pkg::BYTE_W-1:0] b;
        @(posedge rst_n);
        @(negedge clk);
        while (byte_stream.size() > 0)
        begin
            b   = byte_stream.pop_front();
            gap = idle_len();
            if (gap > 0)
            begin
                rx_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            rx_ch.valid   <= 1'b1;
            rx_ch.rx_byte <= b;
            @(posedge clk);
            while (!rx_ch.ready) @(posedge clk);
            bytes_sent++;
            @(negedge clk);
        end
        rx_ch.valid <= 1'b0;

        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fails == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Key receiver, with one long hold-off to fill the block
    initial
    begin
        int  gap;
        bit  held;
        held = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (!held && bytes_sent >= HOLD_AFTER)
            begin
                held = 1'b1;
                key_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            gap = idle_len();
            if (gap > 0)
            begin
                key_ch.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            key_ch.ready <= 1'b1;
            @(negedge clk);
        end
    end

    // Give up when nothing moves on either channel for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((rx_ch.valid && rx_ch.ready) || (key_ch.valid && key_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/tekd_pkg.sv
sv/tekd_if.sv
sv/tekd_in_stage.sv
sv/tekd_core.sv
sv/tekd_out_stage.sv
sv/terminal_escape_key_decoder.sv
verif/tekd_key_checker.sv
verif/testbench.sv
